FILE: hdl/tdpt_pkg.sv
// Package: types, constants and microcode ROM of the trial division prime test unit.
package tdpt_pkg;

   // Default width of the number under test
   localparam int NUMBER_WIDTH_DEF = 32;

   // Width of the microprogram counter
   localparam int UPC_WIDTH = 4;

   // Microprogram steps
   typedef enum logic [UPC_WIDTH-1:0] {
      STEP_IDLE      = 4'd0,
      STEP_SMALL     = 4'd1,
      STEP_DIV_INIT  = 4'd2,
      STEP_DIV_SHIFT = 4'd3,
      STEP_Q_TEST    = 4'd4,
      STEP_R_TEST    = 4'd5,
      STEP_NEXT_DIV  = 4'd6,
      STEP_PRIME     = 4'd7,
      STEP_COMPOSITE = 4'd8
   } upc_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NEVER    = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_NO_START = 3'd2,
      COND_N_LT_2   = 3'd3,
      COND_DIV_MORE = 3'd4,
      COND_Q_LT_D   = 3'd5,
      COND_R_ZERO   = 3'd6
   } cond_type;

   // One control word: jump condition and target, then datapath actions
   typedef struct packed {
      cond_type cond;
      upc_type  target;
      logic     load;       // take candidate, divisor back to two
      logic     div_init;   // clear remainder, quotient register gets n
      logic     div_shift;  // one restoring division bit
      logic     inc_d;      // next trial divisor
      logic     emit;       // present the result
      logic     prime;      // verdict presented with emit
   } ctrl_word_type;

   // Status from the datapath, used by jump conditions
   typedef struct packed {
      logic n_lt_2;
      logic div_more;
      logic q_lt_d;
      logic r_zero;
   } dp_status_type;

   // Microcode ROM
   function automatic ctrl_word_type step_rom(input upc_type upc);
      ctrl_word_type cw;
      cw = '0;
      cw.cond   = COND_NEVER;
      cw.target = STEP_IDLE;
      unique case (upc)
         STEP_IDLE: begin
            cw.cond   = COND_NO_START;
            cw.target = STEP_IDLE;
            cw.load   = 1'b1;
         end
         STEP_SMALL: begin
            cw.cond   = COND_N_LT_2;
            cw.target = STEP_COMPOSITE;
         end
         STEP_DIV_INIT: begin
            cw.div_init = 1'b1;
         end
         STEP_DIV_SHIFT: begin
            cw.cond      = COND_DIV_MORE;
            cw.target    = STEP_DIV_SHIFT;
            cw.div_shift = 1'b1;
         end
         STEP_Q_TEST: begin
            // quotient below divisor: divisor squared exceeds n
            cw.cond   = COND_Q_LT_D;
            cw.target = STEP_PRIME;
         end
         STEP_R_TEST: begin
            cw.cond   = COND_R_ZERO;
            cw.target = STEP_COMPOSITE;
         end
         STEP_NEXT_DIV: begin
            cw.cond   = COND_ALWAYS;
            cw.target = STEP_DIV_INIT;
            cw.inc_d  = 1'b1;
         end
         STEP_PRIME: begin
            cw.cond   = COND_ALWAYS;
            cw.target = STEP_IDLE;
            cw.emit   = 1'b1;
            cw.prime  = 1'b1;
         end
         STEP_COMPOSITE: begin
            cw.cond   = COND_ALWAYS;
            cw.target = STEP_IDLE;
            cw.emit   = 1'b1;
         end
         default: begin
            cw.cond   = COND_ALWAYS;
            cw.target = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

FILE: hdl/tdpt_sequencer.sv
// Microprogram sequencer: step counter, microcode ROM lookup and conditional jumps.
module tdpt_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  tdpt_pkg::dp_status_type status,
   output tdpt_pkg::ctrl_word_type ctrl,
   output logic                    busy
);

   tdpt_pkg::upc_type upc_ff;
   tdpt_pkg::upc_type upc_in;
   logic              jump;

   // Current control word
   assign ctrl = tdpt_pkg::step_rom(upc_ff);
   assign busy = (upc_ff != tdpt_pkg::STEP_IDLE);

   // Condition select
   always_comb begin
      unique case (ctrl.cond)
         tdpt_pkg::COND_NEVER:    jump = 1'b0;
         tdpt_pkg::COND_ALWAYS:   jump = 1'b1;
         tdpt_pkg::COND_NO_START: jump = !start;
         tdpt_pkg::COND_N_LT_2:   jump = status.n_lt_2;
         tdpt_pkg::COND_DIV_MORE: jump = status.div_more;
         tdpt_pkg::COND_Q_LT_D:   jump = status.q_lt_d;
         tdpt_pkg::COND_R_ZERO:   jump = status.r_zero;
         default:                 jump = 1'b0;
      endcase
   end

   // Next step: jump target or fall through
   always_comb begin
      if (jump) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = tdpt_pkg::upc_type'(upc_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= tdpt_pkg::STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

FILE: hdl/tdpt_datapath.sv
// Datapath: number and divisor registers, bit-serial restoring divider, result register.
module tdpt_datapath #(
   parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] candidate,
   input  tdpt_pkg::ctrl_word_type ctrl,
   output tdpt_pkg::dp_status_type status,
   output logic                    strobe,
   output logic [NUMBER_WIDTH-1:0] tested_number,
   output logic                    is_prime
);

   localparam int CNT_WIDTH = $clog2(NUMBER_WIDTH + 1);

   logic [NUMBER_WIDTH-1:0] n_ff,   n_in;
   logic [NUMBER_WIDTH-1:0] d_ff,   d_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH-1:0] quo_ff, quo_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic                    strobe_ff, strobe_in;
   logic                    prime_ff,  prime_in;

   logic [NUMBER_WIDTH:0]   shifted;
   logic [NUMBER_WIDTH:0]   diff;
   logic                    fits;

   // One restoring division bit
   assign shifted = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
   assign diff    = shifted - {1'b0, d_ff};
   assign fits    = !diff[NUMBER_WIDTH];

   // Register updates per control word
   always_comb begin
      n_in      = n_ff;
      d_in      = d_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      strobe_in = ctrl.emit;
      prime_in  = prime_ff;
      if (ctrl.load && start) begin
         n_in = candidate;
         d_in = NUMBER_WIDTH'(2);
      end
      if (ctrl.div_init) begin
         rem_in = '0;
         quo_in = n_ff;
         cnt_in = CNT_WIDTH'(NUMBER_WIDTH);
      end
      if (ctrl.div_shift) begin
         rem_in = fits ? diff[NUMBER_WIDTH-1:0] : shifted[NUMBER_WIDTH-1:0];
         quo_in = {quo_ff[NUMBER_WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
      if (ctrl.inc_d) begin
         d_in = d_ff + 1'b1;
      end
      if (ctrl.emit) begin
         prime_in = ctrl.prime;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
   end

   // Status for the sequencer
   assign status.n_lt_2   = (n_ff < NUMBER_WIDTH'(2));
   assign status.div_more = (cnt_ff != CNT_WIDTH'(1));
   assign status.q_lt_d   = (quo_ff < d_ff);
   assign status.r_zero   = (rem_ff == '0);

   assign strobe        = strobe_ff;
   assign tested_number = n_ff;
   assign is_prime      = prime_ff;

endmodule

FILE: hdl/trial_division_prime_test_unit.sv
// Top level of the trial division prime test unit.
//
//  Channel   Ports                                        Handshake
//  request   start, req_candidate                         taken when start && !busy
//  result    rsp_strobe, rsp_tested_number, rsp_is_prime  one cycle strobe, no stall
//
// A request runs the divider once per trial divisor, from 2 up to at most
// floor(sqrt(n)) + 1, then ends in the prime or composite step; candidates
// below 2 go straight to the composite step. The bit-serial divider, one
// quotient bit per cycle, dominates the time a request takes.
// busy is high from the cycle after a request is taken until the result strobe.
// Reset clears the sequencer and the strobe; the receiver cannot stall the result.
module trial_division_prime_test_unit #(
   parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [NUMBER_WIDTH-1:0] req_candidate,
   output logic                    rsp_strobe,
   output logic [NUMBER_WIDTH-1:0] rsp_tested_number,
   output logic                    rsp_is_prime
);

   tdpt_pkg::ctrl_word_type ctrl;
   tdpt_pkg::dp_status_type status;

   tdpt_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   tdpt_datapath #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .candidate     (req_candidate),
      .ctrl          (ctrl),
      .status        (status),
      .strobe        (rsp_strobe),
      .tested_number (rsp_tested_number),
      .is_prime      (rsp_is_prime)
   );

endmodule

FILE: hdl/tdpt_checker.sv
// Port-level checker of the trial division prime test unit, bound to the top level.
module tdpt_checker #(
   parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic [NUMBER_WIDTH-1:0] req_candidate,
   input logic                    rsp_strobe,
   input logic [NUMBER_WIDTH-1:0] rsp_tested_number,
   input logic                    rsp_is_prime
);

   // A taken request makes the unit busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but unit not busy");

   // A result ends a busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe outside end of a test");

   // One result per request: strobes never back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("repeated result strobe");

   // Zero and one are never prime
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_tested_number < NUMBER_WIDTH'(2))) |-> !rsp_is_prime)
      else $error("number below two reported prime");

   // Echoed number is the one taken with the request, checked for a candidate of four
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_candidate == NUMBER_WIDTH'(4))) |=>
         (rsp_tested_number == NUMBER_WIDTH'(4)))
      else $error("echoed number differs from request");

endmodule

bind trial_division_prime_test_unit tdpt_checker #(
   .NUMBER_WIDTH (NUMBER_WIDTH)
) u_tdpt_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_candidate     (req_candidate),
   .rsp_strobe        (rsp_strobe),
   .rsp_tested_number (rsp_tested_number),
   .rsp_is_prime      (rsp_is_prime)
);
